[hw/rtl/lr_pkg.sv]
`timescale 1ns / 1ps

package lr_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;

    localparam int X_W     = 6;
    localparam int Y_W     = 5;
    localparam int ADDR_W  = 11;
    localparam int DELTA_W = 7;
    localparam int ERR_W   = 8;
    localparam int CNT_W   = 6;
    localparam int MAX_PIXELS = 64;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_DRAW = 1'b1
    } lr_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } lr_cmd_t;

    typedef struct packed {
        logic last;
    } lr_status_t;

endpackage

[hw/rtl/lr_ctrl.sv]
`timescale 1ns / 1ps

module lr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  lr_pkg::lr_status_t status,
    output lr_pkg::lr_cmd_t    cmd
);
    import lr_pkg::*;

    lr_state_t state_reg;
    lr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/lr_datapath.sv]
`timescale 1ns / 1ps

module lr_datapath (
    input  logic                        aclk,
    input  lr_pkg::lr_cmd_t             cmd,
    input  logic [lr_pkg::X_W-1:0]      start_x,
    input  logic [lr_pkg::Y_W-1:0]      start_y,
    input  logic [lr_pkg::X_W-1:0]      end_x,
    input  logic [lr_pkg::Y_W-1:0]      end_y,
    output logic [lr_pkg::X_W-1:0]      pixel_x,
    output logic [lr_pkg::Y_W-1:0]      pixel_y,
    output logic [lr_pkg::ADDR_W-1:0]   pixel_address,
    output lr_pkg::lr_status_t          status
);
    import lr_pkg::*;

    logic [X_W-1:0]            x_reg, x_next;
    logic [Y_W-1:0]            y_reg, y_next;
    logic [X_W-1:0]            ex_reg, ex_next;
    logic [Y_W-1:0]            ey_reg, ey_next;
    logic signed [DELTA_W-1:0] dx_reg, dx_next;
    logic signed [DELTA_W-1:0] dy_reg, dy_next;
    logic                      sx_neg_reg, sx_neg_next;
    logic                      sy_neg_reg, sy_neg_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;

    logic signed [DELTA_W-1:0] ld_dx, ld_dy;
    logic signed [ERR_W:0]     e2;
    logic signed [ERR_W:0]     dx_ext, dy_ext;
    logic                      move_x, move_y;
    logic signed [ERR_W-1:0]   err_add_x, err_add_y;

    always_comb begin
        if (end_x >= start_x) begin
            ld_dx = DELTA_W'(end_x) - DELTA_W'(start_x);
        end else begin
            ld_dx = DELTA_W'(start_x) - DELTA_W'(end_x);
        end
        if (end_y >= start_y) begin
            ld_dy = DELTA_W'(start_y) - DELTA_W'(end_y);
        end else begin
            ld_dy = DELTA_W'(end_y) - DELTA_W'(start_y);
        end
    end

    assign e2     = {err_reg, 1'b0};
    assign dx_ext = (ERR_W + 1)'(dx_reg);
    assign dy_ext = (ERR_W + 1)'(dy_reg);
    assign move_x = (e2 >= dy_ext);
    assign move_y = (e2 <= dx_ext);
    assign err_add_x = move_x ? ERR_W'(dy_reg) : '0;
    assign err_add_y = move_y ? ERR_W'(dx_reg) : '0;

    always_comb begin
        x_next      = x_reg;
        y_next      = y_reg;
        ex_next     = ex_reg;
        ey_next     = ey_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        err_next    = err_reg;
        cnt_next    = cnt_reg;
        if (cmd.load) begin
            x_next      = start_x;
            y_next      = start_y;
            ex_next     = end_x;
            ey_next     = end_y;
            dx_next     = ld_dx;
            dy_next     = ld_dy;
            sx_neg_next = !(start_x < end_x);
            sy_neg_next = !(start_y < end_y);
            err_next    = ERR_W'(ld_dx) + ERR_W'(ld_dy);
            cnt_next    = '0;
        end else if (cmd.step) begin
            err_next = err_reg + err_add_x + err_add_y;
            if (move_x) begin
                x_next = sx_neg_reg ? x_reg - X_W'(1) : x_reg + X_W'(1);
            end
            if (move_y) begin
                y_next = sy_neg_reg ? y_reg - Y_W'(1) : y_reg + Y_W'(1);
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        err_reg    <= err_next;
        cnt_reg    <= cnt_next;
    end

    assign pixel_x       = x_reg;
    assign pixel_y       = y_reg;
    assign pixel_address = ADDR_W'(32'(y_reg) * SCREEN_WIDTH + 32'(x_reg));
    assign status.last   = ((x_reg == ex_reg) && (y_reg == ey_reg))
                           || (cnt_reg == CNT_W'(MAX_PIXELS - 1));

endmodule

[hw/rtl/line_rasterizer_top.sv]
`timescale 1ns / 1ps

// Bresenham line rasterizer.
// Input channel (s_*): one transaction carries a segment, start and end pixel.
// Output channel (m_*): one transaction per plotted pixel, start to end
// inclusive, with column, row, row-major frame buffer address and a last flag.
// A segment yields max(|dx|, |dy|) + 1 pixels, 1 to 64.
// The first pixel is valid in the cycle after the segment is accepted; with
// m_ready held high one pixel follows every cycle. The error-term iteration
// in the datapath sets that rate: one step per cycle while m_ready is high.
// s_ready is high only while no segment is in progress; the next segment is
// taken in the cycle after the last pixel transaction.
// When the receiver stalls, the current pixel holds on m_* and the iteration
// pauses; nothing is dropped.
// Reset (aresetn low, synchronous) returns the controller to idle and
// abandons any segment in progress.
module line_rasterizer_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lr_pkg::X_W-1:0]      s_start_x,
    input  logic [lr_pkg::Y_W-1:0]      s_start_y,
    input  logic [lr_pkg::X_W-1:0]      s_end_x,
    input  logic [lr_pkg::Y_W-1:0]      s_end_y,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lr_pkg::X_W-1:0]      m_pixel_x,
    output logic [lr_pkg::Y_W-1:0]      m_pixel_y,
    output logic [lr_pkg::ADDR_W-1:0]   m_pixel_address,
    output logic                        m_last_pixel
);
    import lr_pkg::*;

    lr_cmd_t    cmd;
    lr_status_t status;

    lr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lr_datapath u_datapath (
        .aclk          (aclk),
        .cmd           (cmd),
        .start_x       (s_start_x),
        .start_y       (s_start_y),
        .end_x         (s_end_x),
        .end_y         (s_end_y),
        .pixel_x       (m_pixel_x),
        .pixel_y       (m_pixel_y),
        .pixel_address (m_pixel_address),
        .status        (status)
    );

    assign m_last_pixel = status.last;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import lr_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int CALM_TAIL    = 30;
    localparam int RANDOM_SEGS  = 250;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [X_W-1:0] sx;
        logic [Y_W-1:0] sy;
        logic [X_W-1:0] ex;
        logic [Y_W-1:0] ey;
    } segment_t;

    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } pixel_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [X_W-1:0]       s_start_x = '0;
    logic [Y_W-1:0]       s_start_y = '0;
    logic [X_W-1:0]       s_end_x = '0;
    logic [Y_W-1:0]       s_end_y = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [X_W-1:0]       m_pixel_x;
    logic [Y_W-1:0]       m_pixel_y;
    logic [ADDR_W-1:0]    m_pixel_address;
    logic                 m_last_pixel;

    segment_t pending_segments[$];
    pixel_t   expected_pixels[$];
    int       segments_total = 0;
    int       segments_accepted = 0;
    int       errors = 0;
    int       cycles = 0;
    int       send_gap = 0;
    int       send_steady = 0;
    int       recv_stall = 0;
    int       recv_steady = 0;
    bit       calm;
    segment_t next_seg;
    pixel_t   got;
    pixel_t   want;

    line_rasterizer_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_x       (s_start_x),
        .s_start_y       (s_start_y),
        .s_end_x         (s_end_x),
        .s_end_y         (s_end_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_x       (m_pixel_x),
        .m_pixel_y       (m_pixel_y),
        .m_pixel_address (m_pixel_address),
        .m_last_pixel    (m_last_pixel)
    );

    always #10 aclk = ~aclk;

    assign calm = (segments_accepted + CALM_TAIL >= segments_total);

    // Bresenham walk, all octants, start to end inclusive
    function automatic void trace_line(segment_t seg);
        int x, y, tx, ty, dx, ndy, stx, sty, err, e2, n;
        bit done;
        pixel_t p;
        x   = int'(seg.sx);
        y   = int'(seg.sy);
        tx  = int'(seg.ex);
        ty  = int'(seg.ey);
        dx  = (tx >= x) ? tx - x : x - tx;
        ndy = (ty >= y) ? y - ty : ty - y;
        stx = (x < tx) ? 1 : -1;
        sty = (y < ty) ? 1 : -1;
        err = dx + ndy;
        n   = 0;
        done = 1'b0;
        while (!done && n < MAX_PIXELS) begin
            done   = (x == tx && y == ty) || (n == MAX_PIXELS - 1);
            p.x    = x[X_W-1:0];
            p.y    = y[Y_W-1:0];
            p.addr = ADDR_W'(y[Y_W-1:0] * SCREEN_WIDTH + x[X_W-1:0]);
            p.last = done;
            expected_pixels.push_back(p);
            n++;
            if (!done) begin
                e2 = 2 * err;
                if (e2 >= ndy) begin
                    err += ndy;
                    x += stx;
                end
                if (e2 <= dx) begin
                    err += dx;
                    y += sty;
                end
            end
        end
    endfunction

    task automatic add_segment(int sx, int sy, int ex, int ey);
        segment_t seg;
        seg.sx = X_W'(sx);
        seg.sy = Y_W'(sy);
        seg.ex = X_W'(ex);
        seg.ey = Y_W'(ey);
        pending_segments.push_back(seg);
        segments_total++;
    endtask

    // segment driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                next_seg.sx = s_start_x;
                next_seg.sy = s_start_y;
                next_seg.ex = s_end_x;
                next_seg.ey = s_end_y;
                trace_line(next_seg);
                segments_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap == 0 && send_steady == 0 && !calm && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(1, 6);
                    send_steady = $urandom_range(0, 1) ? $urandom_range(5, 20) : 0;
                end
                if (send_gap > 0 && !calm) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_segments.size() > 0) begin
                    if (send_steady > 0)
                        send_steady--;
                    next_seg = pending_segments.pop_front();
                    s_start_x <= next_seg.sx;
                    s_start_y <= next_seg.sy;
                    s_end_x   <= next_seg.ex;
                    s_end_y   <= next_seg.ey;
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.x    = m_pixel_x;
                got.y    = m_pixel_y;
                got.addr = m_pixel_address;
                got.last = m_last_pixel;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel transaction x=%0d y=%0d addr=%0d last=%0d",
                             $time, got.x, got.y, got.addr, got.last);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.x !== want.x) begin
                        $display("%0t: pixel_x expected %0d actual %0d", $time, want.x, got.x);
                        errors++;
                    end
                    if (got.y !== want.y) begin
                        $display("%0t: pixel_y expected %0d actual %0d", $time, want.y, got.y);
                        errors++;
                    end
                    if (got.addr !== want.addr) begin
                        $display("%0t: pixel_address expected %0d actual %0d",
                                 $time, want.addr, got.addr);
                        errors++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last_pixel expected %0d actual %0d",
                                 $time, want.last, got.last);
                        errors++;
                    end
                end
            end
            if (recv_steady > 0)
                recv_steady--;
            if (recv_stall == 0 && recv_steady == 0 && !calm && $urandom_range(0, 5) == 0) begin
                recv_stall = $urandom_range(1, 6);
                recv_steady = $urandom_range(0, 1) ? $urandom_range(10, 60) : 0;
            end
            if (recv_stall > 0 && !calm) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                recv_stall = 0;
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d of %0d segments accepted, %0d pixels pending",
                     $time, segments_accepted, segments_total, expected_pixels.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int sx, sy, ex, ey;

        // single pixel
        add_segment(0, 0, 0, 0);
        add_segment(63, 31, 63, 31);
        // full diagonals, both directions
        add_segment(0, 0, 63, 31);
        add_segment(63, 31, 0, 0);
        add_segment(0, 31, 63, 0);
        add_segment(63, 0, 0, 31);
        // horizontal and vertical
        add_segment(0, 5, 63, 5);
        add_segment(63, 20, 0, 20);
        add_segment(10, 0, 10, 31);
        add_segment(42, 31, 42, 0);
        // 45 degrees
        add_segment(0, 0, 31, 31);
        add_segment(40, 31, 9, 0);
        add_segment(20, 0, 51, 31);
        add_segment(50, 31, 19, 0);
        // shallow and steep
        add_segment(0, 0, 63, 1);
        add_segment(0, 0, 1, 31);
        add_segment(63, 30, 0, 31);
        add_segment(31, 31, 30, 0);
        // unit steps
        add_segment(5, 5, 6, 6);
        add_segment(5, 5, 4, 5);
        add_segment(5, 5, 5, 4);
        add_segment(5, 5, 4, 6);

        for (int i = 0; i < RANDOM_SEGS; i++) begin
            sx = $urandom_range(0, 63);
            sy = $urandom_range(0, 31);
            if ($urandom_range(0, 9) < 3) begin
                ex = sx + $urandom_range(0, 6) - 3;
                ey = sy + $urandom_range(0, 6) - 3;
                ex = (ex < 0) ? 0 : (ex > 63) ? 63 : ex;
                ey = (ey < 0) ? 0 : (ey > 31) ? 31 : ey;
            end else begin
                ex = $urandom_range(0, 63);
                ey = $urandom_range(0, 31);
            end
            add_segment(sx, sy, ex, ey);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        wait (segments_accepted == segments_total);
        wait (expected_pixels.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0t: %0d mismatches, %0d pixels never seen",
                     $time, errors, expected_pixels.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
